// ===== design/relocation_delta_encoder_core_macros.svh =====
// assertion macros for the relocation delta encoder core
// the macros expect signals named clk and rst_n in the including scope
`ifndef RELOCATION_DELTA_ENCODER_CORE_MACROS_SVH
`define RELOCATION_DELTA_ENCODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RDE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RDE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rde_pkg.sv =====
// shared types and constants of the relocation delta encoder
// used by the front, queue, back and top level files; no dependencies
`timescale 1ns / 1ps

package rde_pkg;

  localparam int OFFSET_BITS   = 24;
  localparam int SIZE_BITS     = 25;
  localparam int BYTE_BITS     = 8;
  localparam int REPEAT_BITS   = 17;
  localparam int STATUS_BITS   = 2;
  localparam int IN_DATA_BITS  = 24;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 32;
  localparam int QUEUE_DEPTH   = 4;

  // tuser bit places on the input side
  localparam int IN_USER_OP  = 0;
  localparam int IN_USER_ABS = 1;

  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_END   = 1'b1;

  localparam logic [BYTE_BITS-1:0] SKIP_BYTE  = 8'h01;
  localparam logic [BYTE_BITS-1:0] TERM_BYTE  = 8'h00;
  localparam logic [8:0]           SKIP_WORTH = 9'd254;

  // (delta-1)/254 = ((delta-1)>>1)/127, reciprocal of 127 scaled by 2^30, rounded down
  localparam int DIV_SHIFT     = 30;
  localparam int DIV_MULT_BITS = 24;
  localparam logic [DIV_MULT_BITS-1:0] DIV_MULT = 24'd8454660;
  localparam int PROD_BITS     = OFFSET_BITS - 1 + DIV_MULT_BITS;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_ORDER = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_TERM,
    CMD_ERR_RANGE,
    CMD_ERR_ORDER,
    CMD_FIRST,
    CMD_DELTA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [OFFSET_BITS-1:0] value;  // offset for first entry, distance for delta
  } cmd_t;

  typedef struct packed {
    logic awaiting;
    logic err;
  } front_stat_t;

endpackage

// ===== design/rde_front.sv =====
// front part: holds the image size register and the encoder state,
// checks each request and turns it into at most one command for the queue; uses rde_pkg
`timescale 1ns / 1ps

module rde_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rde_pkg::SIZE_BITS-1:0]       cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rde_pkg::IN_DATA_BITS-1:0]    in_tdata,
  input  logic [rde_pkg::IN_USER_BITS-1:0]    in_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output rde_pkg::cmd_t                       q_data,
  output rde_pkg::front_stat_t                stat
);

  logic [rde_pkg::SIZE_BITS-1:0]   image_size_r;
  logic [rde_pkg::OFFSET_BITS-1:0] prev_r, prev_nxt;
  logic                            awaiting_r, awaiting_nxt;
  logic                            err_r, err_nxt;

  logic                            accept;
  logic                            op;
  logic                            is_abs;
  logic [rde_pkg::OFFSET_BITS-1:0] off;
  logic [rde_pkg::OFFSET_BITS-1:0] delta;
  logic                            out_of_range;

  assign cfg_ready = 1'b1;
  assign in_tready = ~q_full;
  assign accept    = in_tvalid & ~q_full;

  assign op     = in_tuser[rde_pkg::IN_USER_OP];
  assign is_abs = in_tuser[rde_pkg::IN_USER_ABS];
  assign off    = in_tdata[rde_pkg::OFFSET_BITS-1:0];
  assign delta  = off - prev_r;
  assign out_of_range = {1'b0, off} >= image_size_r;

  assign stat.awaiting = awaiting_r;
  assign stat.err      = err_r;

  always_comb begin
    prev_nxt     = prev_r;
    awaiting_nxt = awaiting_r;
    err_nxt      = err_r;
    q_push       = 1'b0;
    q_data.kind  = rde_pkg::CMD_TERM;
    q_data.value = '0;
    if (accept) begin
      priority if (op == rde_pkg::OP_END) begin
        q_push       = 1'b1;
        q_data.kind  = rde_pkg::CMD_TERM;
        prev_nxt     = '0;
        awaiting_nxt = 1'b1;
        err_nxt      = 1'b0;
      end else if (err_r) begin
        // entries are dropped until the next end request
      end else if (out_of_range) begin
        q_push      = 1'b1;
        q_data.kind = rde_pkg::CMD_ERR_RANGE;
        err_nxt     = 1'b1;
      end else if (is_abs) begin
        // absolute entries only get the range check
      end else if (awaiting_r) begin
        q_push       = 1'b1;
        q_data.kind  = rde_pkg::CMD_FIRST;
        q_data.value = off;
        awaiting_nxt = 1'b0;
        prev_nxt     = off;
      end else if (off < prev_r) begin
        q_push      = 1'b1;
        q_data.kind = rde_pkg::CMD_ERR_ORDER;
        err_nxt     = 1'b1;
      end else begin
        prev_nxt     = off;
        q_push       = delta != '0;
        q_data.kind  = rde_pkg::CMD_DELTA;
        q_data.value = delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= '0;
      prev_r       <= '0;
      awaiting_r   <= 1'b1;
      err_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        image_size_r <= cfg_data;
      end
      prev_r     <= prev_nxt;
      awaiting_r <= awaiting_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// ===== design/rde_queue.sv =====
// command queue between the front and back parts
// a small register file with read and write pointers; uses rde_pkg::cmd_t
`timescale 1ns / 1ps

module rde_queue #(
  parameter int DEPTH = rde_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rde_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output rde_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rde_pkg::cmd_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/rde_back.sv =====
// back part: reciprocal multiply stage, run emitter and output register
// takes commands from rde_queue and emits (byte, repeat) runs; uses rde_pkg
`timescale 1ns / 1ps

module rde_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  rde_pkg::cmd_t                        q_data,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rde_pkg::BYTE_BITS-1:0]        out_byte,
  output logic [rde_pkg::REPEAT_BITS-1:0]      out_repeat,
  output logic                                 out_last,
  output rde_pkg::status_t                     out_status
);

  // multiply stage
  logic                              s1_valid_r, s1_valid_nxt;
  rde_pkg::cmd_t                     s1_cmd_r;
  logic [rde_pkg::PROD_BITS-1:0]     s1_prod_r;
  logic [rde_pkg::OFFSET_BITS-1:0]   dec;
  logic [rde_pkg::OFFSET_BITS-2:0]   half;

  // emitter stage
  logic                              s2_valid_r, s2_valid_nxt;
  rde_pkg::cmd_t                     s2_cmd_r;
  logic [rde_pkg::REPEAT_BITS-1:0]   s2_q_r;
  logic [1:0]                        s2_idx_r, s2_idx_nxt;

  logic [8:0]                        q254;
  logic [8:0]                        r9;
  logic                              adj;
  logic [rde_pkg::REPEAT_BITS-1:0]   skips;
  logic [8:0]                        rem9;
  logic                              has_skip;

  logic [rde_pkg::BYTE_BITS-1:0]     cur_byte;
  logic [rde_pkg::REPEAT_BITS-1:0]   cur_repeat;
  logic                              cur_last;
  rde_pkg::status_t                  cur_status;

  logic                              out_valid_r, out_valid_nxt;
  logic [rde_pkg::BYTE_BITS-1:0]     out_byte_r;
  logic [rde_pkg::REPEAT_BITS-1:0]   out_repeat_r;
  logic                              out_last_r;
  rde_pkg::status_t                  out_status_r;

  logic                              out_ld;
  logic                              s2_free;
  logic                              s1_move;
  logic                              s1_free;

  assign out_ld  = s2_valid_r & (~out_valid_r | out_ready);
  assign s2_free = ~s2_valid_r | (out_ld & cur_last);
  assign s1_move = s1_valid_r & s2_free;
  assign s1_free = ~s1_valid_r | s1_move;
  assign q_pop   = ~q_empty & s1_free;

  // skips = (delta-1)/254 estimated low by at most one
  assign dec  = q_data.value - 1'b1;
  assign half = dec[rde_pkg::OFFSET_BITS-1:1];

  // exact correction on the low nine bits: remainder lies in 1..508 before the fix
  assign q254     = {s2_q_r[0], 8'b0} - {s2_q_r[7:0], 1'b0};
  assign r9       = s2_cmd_r.value[8:0] - q254;
  assign adj      = r9 > rde_pkg::SKIP_WORTH;
  assign skips    = s2_q_r + rde_pkg::REPEAT_BITS'(adj);
  assign rem9     = adj ? r9 - rde_pkg::SKIP_WORTH : r9;
  assign has_skip = skips != '0;

  always_comb begin
    cur_byte   = rde_pkg::TERM_BYTE;
    cur_repeat = rde_pkg::REPEAT_BITS'(1);
    cur_last   = 1'b1;
    cur_status = rde_pkg::STATUS_OK;
    unique case (s2_cmd_r.kind)
      rde_pkg::CMD_TERM: begin
        cur_byte = rde_pkg::TERM_BYTE;
      end
      rde_pkg::CMD_ERR_RANGE: begin
        cur_repeat = '0;
        cur_status = rde_pkg::STATUS_RANGE;
      end
      rde_pkg::CMD_ERR_ORDER: begin
        cur_repeat = '0;
        cur_status = rde_pkg::STATUS_ORDER;
      end
      rde_pkg::CMD_FIRST: begin
        // big-endian longword, top byte is always zero for a 24-bit offset
        cur_last = s2_idx_r == 2'd3;
        unique case (s2_idx_r)
          2'd0:    cur_byte = '0;
          2'd1:    cur_byte = s2_cmd_r.value[23:16];
          2'd2:    cur_byte = s2_cmd_r.value[15:8];
          default: cur_byte = s2_cmd_r.value[7:0];
        endcase
      end
      rde_pkg::CMD_DELTA: begin
        if (has_skip && s2_idx_r == 2'd0) begin
          cur_byte   = rde_pkg::SKIP_BYTE;
          cur_repeat = skips;
          cur_last   = 1'b0;
        end else begin
          cur_byte = rem9[rde_pkg::BYTE_BITS-1:0];
        end
      end
      default: begin
        cur_repeat = '0;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_pop) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    s2_idx_nxt   = s2_idx_r;
    if (s1_move) begin
      s2_valid_nxt = 1'b1;
      s2_idx_nxt   = '0;
    end else if (out_ld && cur_last) begin
      s2_valid_nxt = 1'b0;
    end else if (out_ld) begin
      s2_idx_nxt = s2_idx_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r  <= q_data;
      s1_prod_r <= rde_pkg::PROD_BITS'(half) * rde_pkg::PROD_BITS'(rde_pkg::DIV_MULT);
    end
    if (s1_move) begin
      s2_cmd_r <= s1_cmd_r;
      s2_q_r   <= s1_prod_r[rde_pkg::DIV_SHIFT +: rde_pkg::REPEAT_BITS];
    end
    if (out_ld) begin
      out_byte_r   <= cur_byte;
      out_repeat_r <= cur_repeat;
      out_last_r   <= cur_last;
      out_status_r <= cur_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s2_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s2_idx_r    <= s2_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_repeat = out_repeat_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

// ===== design/relocation_delta_encoder_core.sv =====
// Relocation delta encoder core: turns a sorted stream of relocation offsets into
// the runs of a delta-coded relocation table.
// Input stream: in_tdata carries the offset, in_tuser the end flag and absolute flag.
// Each request gives zero to four result runs on the output stream; out_tlast marks
// the last run of a request, out_tuser gives the status (ok, out of range, backwards).
// A run with repeat zero is an error report and carries nothing to emit.
// Configuration: cfg_data writes the image size; write it only while the core is idle.
// Path: a request passes the queue, then the multiply, emitter and output registers.
// Throughput: one run per cycle on the output while out_tready is high; a request is taken
// every cycle while the command queue has room, so the sustained rate is set by the run
// count per request (1 or 2 for a distance, 4 for the first entry) at the output register.
// Reset: the image size is zero, the encoder waits for a first entry, the error
// flag is clear and the queue and pipeline are empty. No clearing pass is needed.
// Stall: when out_tready is low the run in the output register holds, the pipeline
// fills, and once the command queue is full in_tready drops.
// Depends on rde_pkg, rde_front, rde_queue, rde_back and the macros header.
`timescale 1ns / 1ps
`include "relocation_delta_encoder_core_macros.svh"

module relocation_delta_encoder_core #(
  parameter int QUEUE_DEPTH = rde_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rde_pkg::SIZE_BITS-1:0]       cfg_data,      // image_size
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rde_pkg::IN_DATA_BITS-1:0]    in_tdata,      // offset
  input  logic [rde_pkg::IN_USER_BITS-1:0]    in_tuser,      // op, is_absolute
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rde_pkg::OUT_DATA_BITS-1:0]   out_tdata,     // out_byte, repeat_res, zero pad
  output logic [rde_pkg::STATUS_BITS-1:0]     out_tuser,     // status
  output logic                                out_tlast
);

  localparam int PAD_BITS = rde_pkg::OUT_DATA_BITS - rde_pkg::BYTE_BITS - rde_pkg::REPEAT_BITS;

  logic                               q_full;
  logic                               q_empty;
  logic                               q_push;
  logic                               q_pop;
  rde_pkg::cmd_t                      q_wdata;
  rde_pkg::cmd_t                      q_rdata;
  rde_pkg::front_stat_t               front_stat;
  logic [rde_pkg::BYTE_BITS-1:0]      res_byte;
  logic [rde_pkg::REPEAT_BITS-1:0]    res_repeat;
  rde_pkg::status_t                   res_status;

  rde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .stat      (front_stat)
  );

  rde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (res_byte),
    .out_repeat (res_repeat),
    .out_last   (out_tlast),
    .out_status (res_status)
  );

  assign out_tdata = {{PAD_BITS{1'b0}}, res_repeat, res_byte};
  assign out_tuser = res_status;

  // an error report is always the final run of its request
  `RDE_ASSERT_IMP(a_err_is_last, out_tvalid && res_status != rde_pkg::STATUS_OK, out_tlast,
    "error report without tlast")

  // a good run always has something to emit
  `RDE_ASSERT_IMP(a_ok_repeat_nonzero, out_tvalid && res_status == rde_pkg::STATUS_OK,
    res_repeat != '0, "ok run with zero repeat")

  // an end request rearms the encoder and clears the error flag
  `RDE_ASSERT_NXT(a_end_rearms,
    in_tvalid && in_tready && in_tuser[rde_pkg::IN_USER_OP] == rde_pkg::OP_END,
    front_stat.awaiting && !front_stat.err, "end request did not rearm")

endmodule
